>>> src/cfd_pkg.sv
// Shared types, constants and helpers of the FLIC chunk decoder.
package cfd_pkg;

    // Defaults of the canvas size limits
    localparam int MAX_WIDTH_DEF  = 320;
    localparam int MAX_HEIGHT_DEF = 200;

    // Column counter width, enough to pass any canvas bound up to 1024 x 1024
    localparam int COL_W = 24;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Sub-chunk type codes
    localparam logic [15:0] CT_COLOR256 = 16'd4;
    localparam logic [15:0] CT_SS2      = 16'd7;
    localparam logic [15:0] CT_COLOR64  = 16'd11;
    localparam logic [15:0] CT_LC       = 16'd12;
    localparam logic [15:0] CT_BLACK    = 16'd13;
    localparam logic [15:0] CT_BYTERUN  = 16'd15;
    localparam logic [15:0] CT_COPY     = 16'd16;

    typedef enum logic [1:0] {
        CMD_RUN   = 2'd0,
        CMD_PAL   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        AC_NONE, AC_COLOR256, AC_COLOR64, AC_BLACK,
        AC_COPY, AC_BYTERUN, AC_LC, AC_SS2
    } chunk_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_CPK_LO, PH_CPK_HI, PH_CSKIP, PH_CCNT, PH_CR, PH_CG, PH_CB,
        PH_COPY, PH_BHEAD, PH_BCODE, PH_BVAL, PH_BLIT,
        PH_LST_LO, PH_LST_HI, PH_LLN_LO, PH_LLN_HI, PH_LPKTS, PH_LSKIP,
        PH_LCODE, PH_LVAL, PH_LLIT,
        PH_SCNT_LO, PH_SCNT_HI, PH_SOP_LO, PH_SOP_HI, PH_SSKIP, PH_SCODE,
        PH_SLIT_LO, PH_SLIT_HI, PH_SRUN_LO, PH_SRUN_HI
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] chunk_type;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] start_address;
        logic [8:0]  run_length;
        logic [7:0]  first_value;
        logic [7:0]  second_value;
        logic        two_value_pattern;
        logic [7:0]  palette_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } out_item_t;

    // Queued command: runs carry row and column, address is formed in the back
    typedef struct packed {
        cmd_t             cmd;
        logic [15:0]      row;
        logic [COL_W-1:0] col;
        logic [8:0]       len;
        logic [7:0]       first;
        logic [7:0]       second;
        logic             two;
        logic [7:0]       pal_idx;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } qentry_t;

    // Saturating column add
    function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] c,
                                                 input logic [9:0] inc);
        logic [COL_W:0] s;
        s = {1'b0, c} + (COL_W+1)'(inc);
        return s[COL_W] ? {COL_W{1'b1}} : s[COL_W-1:0];
    endfunction

    // Row add saturating at 65535
    function automatic logic [15:0] row_add(input logic [15:0] r, input logic [16:0] inc);
        logic [17:0] s;
        s = {2'b0, r} + {1'b0, inc};
        return (s > 18'h0FFFF) ? 16'hFFFF : s[15:0];
    endfunction

endpackage

>>> src/cfd_chan_if.sv
// Valid/ready channel carrying one item.
interface cfd_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/cfd_front.sv
// Front: configuration registers and the byte-level chunk parser.
module cfd_front #(
    parameter int MAX_WIDTH  = cfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cfd_pkg::MAX_HEIGHT_DEF,
    localparam int WB = $clog2(MAX_WIDTH + 1),
    localparam int HB = $clog2(MAX_HEIGHT + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [8:0]        cfg_data,
    cfd_chan_if.sink          in_chan,
    input  logic              q_full,
    output logic              q_push,
    output cfd_pkg::qentry_t  q_data,
    output logic [WB-1:0]     eff_w,
    output logic [HB-1:0]     eff_h
);

    localparam int CW = cfd_pkg::COL_W;

    logic [8:0] width_reg;
    logic [7:0] height_reg;

    cfd_pkg::phase_t phase_reg, phase_next;
    cfd_pkg::chunk_t ac_reg, ac_next;
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic [15:0]   pk_reg, pk_next;
    logic [15:0]   lines_reg, lines_next;
    logic [8:0]    cnt_reg, cnt_next;
    logic [8:0]    ci_reg, ci_next;
    logic [15:0]   held_reg, held_next;
    logic [CW-1:0] cp_reg, cp_next;

    logic       accept;
    logic [7:0] b;
    logic [15:0] pk_dec, lines_dec, op;
    logic [8:0] cnt_dec;
    logic [9:0] ci_sum;
    logic [WB-1:0] wrem;
    logic [8:0] n;
    logic end_pkt, end_line, br_after, br_end;
    logic [7:0] rr, gg, bb;

    // Saturated canvas size
    always_comb
    begin
        if (width_reg == 9'd0)
            eff_w = WB'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = WB'(MAX_WIDTH);
        else
            eff_w = WB'(width_reg);
        if (height_reg == 8'd0)
            eff_h = HB'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = HB'(MAX_HEIGHT);
        else
            eff_h = HB'(height_reg);
    end

    assign in_chan.ready = !q_full;
    assign accept = in_chan.valid && in_chan.ready;
    assign b = in_chan.payload.data_byte;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd320;
            height_reg <= 8'd200;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cfd_pkg::CFG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data[7:0];
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfd_pkg::PH_IDLE;
            ac_reg    <= cfd_pkg::AC_NONE;
            col_reg   <= '0;
            row_reg   <= '0;
            pk_reg    <= '0;
            lines_reg <= '0;
            cnt_reg   <= '0;
            ci_reg    <= '0;
            held_reg  <= '0;
            cp_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ac_reg    <= ac_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pk_reg    <= pk_next;
            lines_reg <= lines_next;
            cnt_reg   <= cnt_next;
            ci_reg    <= ci_next;
            held_reg  <= held_next;
            cp_reg    <= cp_next;
        end
    end

    // Next state and command generation
    always_comb
    begin
        phase_next = phase_reg;
        ac_next    = ac_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pk_next    = pk_reg;
        lines_next = lines_reg;
        cnt_next   = cnt_reg;
        ci_next    = ci_reg;
        held_next  = held_reg;
        cp_next    = cp_reg;
        q_push     = 1'b0;
        q_data     = '0;
        q_data.cmd = cfd_pkg::CMD_RUN;
        end_pkt    = 1'b0;
        end_line   = 1'b0;
        br_after   = 1'b0;
        br_end     = 1'b0;
        pk_dec     = pk_reg - 16'd1;
        lines_dec  = lines_reg - 16'd1;
        cnt_dec    = cnt_reg - 9'd1;
        op         = {b, held_reg[7:0]};
        ci_sum     = {1'b0, ci_reg} + {2'b0, b};
        wrem       = eff_w - WB'(col_reg);
        n          = cnt_reg;
        rr         = held_reg[7:0];
        gg         = held_reg[15:8];
        bb         = b;
        if (ac_reg == cfd_pkg::AC_COLOR64)
        begin
            rr = {rr[5:0], 2'b00};
            gg = {gg[5:0], 2'b00};
            bb = {bb[5:0], 2'b00};
        end
        if (32'(cnt_reg) > 32'(wrem))
            n = 9'(wrem);

        if (accept && !in_chan.payload.kind)
        begin
            // Start marker: drop whatever was in progress
            col_next   = '0;
            row_next   = '0;
            pk_next    = '0;
            lines_next = '0;
            cnt_next   = '0;
            ci_next    = '0;
            held_next  = '0;
            cp_next    = '0;
            phase_next = cfd_pkg::PH_IDLE;
            ac_next    = cfd_pkg::AC_NONE;
            case (in_chan.payload.chunk_type)
                cfd_pkg::CT_COLOR256:
                begin
                    ac_next = cfd_pkg::AC_COLOR256;
                    phase_next = cfd_pkg::PH_CPK_LO;
                end
                cfd_pkg::CT_COLOR64:
                begin
                    ac_next = cfd_pkg::AC_COLOR64;
                    phase_next = cfd_pkg::PH_CPK_LO;
                end
                cfd_pkg::CT_COPY:
                begin
                    ac_next = cfd_pkg::AC_COPY;
                    phase_next = cfd_pkg::PH_COPY;
                end
                cfd_pkg::CT_BYTERUN:
                begin
                    ac_next = cfd_pkg::AC_BYTERUN;
                    phase_next = cfd_pkg::PH_BHEAD;
                end
                cfd_pkg::CT_LC:
                begin
                    ac_next = cfd_pkg::AC_LC;
                    phase_next = cfd_pkg::PH_LST_LO;
                end
                cfd_pkg::CT_SS2:
                begin
                    ac_next = cfd_pkg::AC_SS2;
                    phase_next = cfd_pkg::PH_SCNT_LO;
                end
                cfd_pkg::CT_BLACK:
                begin
                    ac_next = cfd_pkg::AC_BLACK;
                    q_push = 1'b1;
                    q_data.cmd = cfd_pkg::CMD_CLEAR;
                end
                default: ;
            endcase
        end
        else if (accept)
        begin
            case (phase_reg)
                // Palette chunks
                cfd_pkg::PH_CPK_LO:
                begin
                    held_next = {8'd0, b};
                    phase_next = cfd_pkg::PH_CPK_HI;
                end
                cfd_pkg::PH_CPK_HI:
                begin
                    pk_next = op;
                    ci_next = '0;
                    phase_next = (op != 16'd0) ? cfd_pkg::PH_CSKIP : cfd_pkg::PH_IDLE;
                end
                cfd_pkg::PH_CSKIP:
                begin
                    ci_next = (ci_sum > 10'd256) ? 9'd256 : ci_sum[8:0];
                    phase_next = cfd_pkg::PH_CCNT;
                end
                cfd_pkg::PH_CCNT:
                begin
                    cnt_next = (b != 8'd0) ? {1'b0, b} : 9'd256;
                    phase_next = cfd_pkg::PH_CR;
                end
                cfd_pkg::PH_CR:
                begin
                    held_next = {8'd0, b};
                    phase_next = cfd_pkg::PH_CG;
                end
                cfd_pkg::PH_CG:
                begin
                    held_next = {b, held_reg[7:0]};
                    phase_next = cfd_pkg::PH_CB;
                end
                cfd_pkg::PH_CB:
                begin
                    if (!ci_reg[8])
                    begin
                        q_push = 1'b1;
                        q_data.cmd = cfd_pkg::CMD_PAL;
                        q_data.pal_idx = ci_reg[7:0];
                        q_data.red = rr;
                        q_data.green = gg;
                        q_data.blue = bb;
                        ci_next = ci_reg + 9'd1;
                    end
                    cnt_next = cnt_dec;
                    if (cnt_dec == 9'd0)
                    begin
                        pk_next = pk_dec;
                        phase_next = (pk_dec != 16'd0) ? cfd_pkg::PH_CSKIP
                                                       : cfd_pkg::PH_IDLE;
                    end
                    else
                        phase_next = cfd_pkg::PH_CR;
                end
                // Raw copy, the back drops pixels past the bound
                cfd_pkg::PH_COPY:
                begin
                    if (cp_reg != {CW{1'b1}})
                    begin
                        q_push = 1'b1;
                        q_data.col = cp_reg;
                        q_data.len = 9'd1;
                        q_data.first = b;
                        cp_next = cp_reg + CW'(1);
                    end
                end
                // Byte run
                cfd_pkg::PH_BHEAD:
                begin
                    col_next = '0;
                    phase_next = cfd_pkg::PH_BCODE;
                end
                cfd_pkg::PH_BCODE:
                begin
                    if (b == 8'd0)
                        br_end = 1'b1;
                    else if (!b[7])
                    begin
                        cnt_next = {1'b0, b};
                        phase_next = cfd_pkg::PH_BVAL;
                    end
                    else
                    begin
                        cnt_next = 9'd256 - {1'b0, b};
                        phase_next = cfd_pkg::PH_BLIT;
                    end
                end
                cfd_pkg::PH_BVAL:
                begin
                    if (col_reg < CW'(eff_w))
                    begin
                        q_push = 1'b1;
                        q_data.row = row_reg;
                        q_data.col = col_reg;
                        q_data.len = n;
                        q_data.first = b;
                        col_next = cfd_pkg::col_add(col_reg, {1'b0, n});
                    end
                    br_after = 1'b1;
                end
                cfd_pkg::PH_BLIT:
                begin
                    if (col_reg < CW'(eff_w))
                    begin
                        q_push = 1'b1;
                        q_data.row = row_reg;
                        q_data.col = col_reg;
                        q_data.len = 9'd1;
                        q_data.first = b;
                        col_next = cfd_pkg::col_add(col_reg, 10'd1);
                    end
                    cnt_next = cnt_dec;
                    if (cnt_dec == 9'd0)
                        br_after = 1'b1;
                end
                // Byte delta, and the low-byte phases shared with the word delta
                cfd_pkg::PH_LST_LO, cfd_pkg::PH_LLN_LO, cfd_pkg::PH_SCNT_LO,
                cfd_pkg::PH_SOP_LO, cfd_pkg::PH_SLIT_LO, cfd_pkg::PH_SRUN_LO:
                begin
                    held_next = {8'd0, b};
                    case (phase_reg)
                        cfd_pkg::PH_LST_LO:  phase_next = cfd_pkg::PH_LST_HI;
                        cfd_pkg::PH_LLN_LO:  phase_next = cfd_pkg::PH_LLN_HI;
                        cfd_pkg::PH_SCNT_LO: phase_next = cfd_pkg::PH_SCNT_HI;
                        cfd_pkg::PH_SOP_LO:  phase_next = cfd_pkg::PH_SOP_HI;
                        cfd_pkg::PH_SLIT_LO: phase_next = cfd_pkg::PH_SLIT_HI;
                        default:             phase_next = cfd_pkg::PH_SRUN_HI;
                    endcase
                end
                cfd_pkg::PH_LST_HI:
                begin
                    row_next = op;
                    phase_next = cfd_pkg::PH_LLN_LO;
                end
                cfd_pkg::PH_LLN_HI:
                begin
                    lines_next = op;
                    phase_next = (op == 16'd0) ? cfd_pkg::PH_IDLE : cfd_pkg::PH_LPKTS;
                end
                cfd_pkg::PH_LPKTS:
                begin
                    pk_next = {8'd0, b};
                    col_next = '0;
                    if (b == 8'd0)
                        end_line = 1'b1;
                    else
                        phase_next = cfd_pkg::PH_LSKIP;
                end
                cfd_pkg::PH_LSKIP, cfd_pkg::PH_SSKIP:
                begin
                    col_next = cfd_pkg::col_add(col_reg, {2'b0, b});
                    phase_next = (phase_reg == cfd_pkg::PH_LSKIP) ? cfd_pkg::PH_LCODE
                                                                  : cfd_pkg::PH_SCODE;
                end
                cfd_pkg::PH_LCODE, cfd_pkg::PH_SCODE:
                begin
                    if (!b[7])
                    begin
                        cnt_next = {1'b0, b};
                        if (b == 8'd0)
                            end_pkt = 1'b1;
                        else
                            phase_next = (phase_reg == cfd_pkg::PH_LCODE)
                                ? cfd_pkg::PH_LLIT : cfd_pkg::PH_SLIT_LO;
                    end
                    else
                    begin
                        cnt_next = 9'd256 - {1'b0, b};
                        phase_next = (phase_reg == cfd_pkg::PH_LCODE)
                            ? cfd_pkg::PH_LVAL : cfd_pkg::PH_SRUN_LO;
                    end
                end
                cfd_pkg::PH_LLIT:
                begin
                    q_push = 1'b1;
                    q_data.row = row_reg;
                    q_data.col = col_reg;
                    q_data.len = 9'd1;
                    q_data.first = b;
                    col_next = cfd_pkg::col_add(col_reg, 10'd1);
                    cnt_next = cnt_dec;
                    if (cnt_dec == 9'd0)
                        end_pkt = 1'b1;
                end
                cfd_pkg::PH_LVAL:
                begin
                    q_push = 1'b1;
                    q_data.row = row_reg;
                    q_data.col = col_reg;
                    q_data.len = cnt_reg;
                    q_data.first = b;
                    col_next = cfd_pkg::col_add(col_reg, {1'b0, cnt_reg});
                    end_pkt = 1'b1;
                end
                // Word delta
                cfd_pkg::PH_SCNT_HI:
                begin
                    lines_next = op;
                    row_next = '0;
                    phase_next = (op != 16'd0) ? cfd_pkg::PH_SOP_LO : cfd_pkg::PH_IDLE;
                end
                cfd_pkg::PH_SOP_HI:
                begin
                    if (op[15:14] == 2'b11)
                    begin
                        row_next = cfd_pkg::row_add(row_reg, 17'h10000 - {1'b0, op});
                        phase_next = cfd_pkg::PH_SOP_LO;
                    end
                    else if (op[15:14] == 2'b10)
                    begin
                        // Last pixel of the row
                        q_push = 1'b1;
                        q_data.row = row_reg;
                        q_data.col = CW'(eff_w - WB'(1));
                        q_data.len = 9'd1;
                        q_data.first = op[7:0];
                        phase_next = cfd_pkg::PH_SOP_LO;
                    end
                    else
                    begin
                        pk_next = {2'b00, op[13:0]};
                        col_next = '0;
                        if (op[13:0] == 14'd0)
                            end_line = 1'b1;
                        else
                            phase_next = cfd_pkg::PH_SSKIP;
                    end
                end
                cfd_pkg::PH_SLIT_HI:
                begin
                    q_push = 1'b1;
                    q_data.row = row_reg;
                    q_data.col = col_reg;
                    q_data.len = 9'd2;
                    q_data.first = held_reg[7:0];
                    q_data.second = b;
                    q_data.two = 1'b1;
                    col_next = cfd_pkg::col_add(col_reg, 10'd2);
                    cnt_next = cnt_dec;
                    if (cnt_dec == 9'd0)
                        end_pkt = 1'b1;
                    else
                        phase_next = cfd_pkg::PH_SLIT_LO;
                end
                cfd_pkg::PH_SRUN_HI:
                begin
                    q_push = 1'b1;
                    q_data.row = row_reg;
                    q_data.col = col_reg;
                    q_data.len = {cnt_reg[7:0], 1'b0};
                    q_data.first = held_reg[7:0];
                    q_data.second = b;
                    q_data.two = 1'b1;
                    col_next = cfd_pkg::col_add(col_reg, {cnt_reg, 1'b0});
                    end_pkt = 1'b1;
                end
                default: ;
            endcase

            // Packet and line ends of the delta chunks
            if (end_pkt)
            begin
                pk_next = pk_dec;
                if (pk_dec == 16'd0)
                    end_line = 1'b1;
                else
                    phase_next = (ac_reg == cfd_pkg::AC_SS2) ? cfd_pkg::PH_SSKIP
                                                             : cfd_pkg::PH_LSKIP;
            end
            if (end_line)
            begin
                row_next = cfd_pkg::row_add(row_reg, 17'd1);
                lines_next = lines_dec;
                if (lines_dec == 16'd0)
                    phase_next = cfd_pkg::PH_IDLE;
                else
                    phase_next = (ac_reg == cfd_pkg::AC_SS2) ? cfd_pkg::PH_SOP_LO
                                                             : cfd_pkg::PH_LPKTS;
            end

            // Row ends of the byte run chunk
            if (br_after && (col_next >= CW'(eff_w)))
                br_end = 1'b1;
            else if (br_after)
                phase_next = cfd_pkg::PH_BCODE;
            if (br_end)
            begin
                row_next = row_reg + 16'd1;
                phase_next = (32'(row_reg) + 1 >= 32'(eff_h)) ? cfd_pkg::PH_IDLE
                                                              : cfd_pkg::PH_BHEAD;
            end
        end
    end

endmodule

>>> src/cfd_queue.sv
// Small command queue between the parser and the address stage.
module cfd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cfd_pkg::qentry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output cfd_pkg::qentry_t head
);

    cfd_pkg::qentry_t mem [cfd_pkg::QDEPTH];
    logic [cfd_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [cfd_pkg::QCNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == cfd_pkg::QCNT_W'(cfd_pkg::QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign head    = mem[rd_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + cfd_pkg::QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + cfd_pkg::QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + cfd_pkg::QCNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - cfd_pkg::QCNT_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid) else $error("queue pop while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + cfd_pkg::QCNT_W'(1)))
        else $error("queue count did not follow push");
`endif

endmodule

>>> src/cfd_back.sv
// Back: canvas address, bound clipping and the output register.
module cfd_back #(
    parameter int MAX_WIDTH  = cfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cfd_pkg::MAX_HEIGHT_DEF,
    localparam int WB = $clog2(MAX_WIDTH + 1),
    localparam int HB = $clog2(MAX_HEIGHT + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WB-1:0]    eff_w,
    input  logic [HB-1:0]    eff_h,
    input  logic             q_valid,
    input  cfd_pkg::qentry_t head,
    output logic             pop,
    cfd_chan_if.source       out_chan
);

    localparam int NPW  = WB + HB;
    localparam int PW   = 16 + WB;
    localparam int AW   = ((PW > cfd_pkg::COL_W) ? PW : cfd_pkg::COL_W) + 1;
    localparam int LW   = (NPW > 9) ? NPW : 9;

    logic             s1_v_reg;
    cfd_pkg::qentry_t s1_e_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [NPW-1:0]   s1_npix_reg;
    logic             out_v_reg;
    cfd_pkg::out_item_t out_reg;

    logic           s1_ready, adv, keep, in_bound;
    logic [NPW-1:0] rem;
    logic [8:0]     len;
    cfd_pkg::out_item_t o;

    assign s1_ready = !s1_v_reg || !out_v_reg || out_chan.ready;
    assign pop      = s1_ready && q_valid;
    assign adv      = s1_v_reg && (!out_v_reg || out_chan.ready);

    // Address stage: row times stride plus column, and the bound
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_e_reg    <= head;
            s1_addr_reg <= AW'(head.row) * AW'(eff_w) + AW'(head.col);
            s1_npix_reg <= NPW'(eff_w) * NPW'(eff_h);
        end
    end

    // Clip and form the result
    always_comb
    begin
        in_bound = s1_addr_reg < AW'(s1_npix_reg);
        rem      = s1_npix_reg - s1_addr_reg[NPW-1:0];
        len      = s1_e_reg.len;
        if (LW'(rem) < LW'(s1_e_reg.len))
            len = 9'(rem);
        keep = (s1_e_reg.cmd != cfd_pkg::CMD_RUN) || in_bound;
        o.command           = s1_e_reg.cmd;
        o.start_address     = s1_addr_reg[15:0];
        o.run_length        = (s1_e_reg.cmd == cfd_pkg::CMD_RUN) ? len : 9'd0;
        o.first_value       = s1_e_reg.first;
        o.second_value      = s1_e_reg.second;
        o.two_value_pattern = s1_e_reg.two;
        o.palette_index     = s1_e_reg.pal_idx;
        o.red               = s1_e_reg.red;
        o.green             = s1_e_reg.green;
        o.blue              = s1_e_reg.blue;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= o;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_v_reg <= q_valid;
            if (adv)
                out_v_reg <= keep;
            else if (out_chan.ready)
                out_v_reg <= 1'b0;
        end
    end

    assign out_chan.valid   = out_v_reg;
    assign out_chan.payload = out_reg;

endmodule

>>> src/flic_chunk_decoder.sv
// Top level of the FLIC sub-chunk decoder.
// Takes one byte item (or a start marker) per clock and returns at most one
// canvas command per item: a clipped pixel run, a palette entry or a clear.
// Sustained rate is one item per cycle; a command is parsed at the edge
// that accepts its item into the four-entry queue, then passes the address
// multiply stage, then the output register. Input stalls only when the
// queue is full, which happens only while the output side is held.
// The user must write frame_width and frame_height through
// cfg_we/cfg_index/cfg_data while idle; the block does not enforce this.
module flic_chunk_decoder #(
    parameter int MAX_WIDTH  = cfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cfd_pkg::MAX_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    cfd_chan_if.sink   in_chan,
    cfd_chan_if.source out_chan
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    logic             q_full, q_push, q_pop, q_valid;
    cfd_pkg::qentry_t q_in, q_head;
    logic [WB-1:0]    eff_w;
    logic [HB-1:0]    eff_h;

    cfd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_chan(in_chan),
        .q_full(q_full), .q_push(q_push), .q_data(q_in),
        .eff_w(eff_w), .eff_h(eff_h)
    );

    cfd_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .q_valid(q_valid), .head(q_head)
    );

    cfd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n),
        .eff_w(eff_w), .eff_h(eff_h),
        .q_valid(q_valid), .head(q_head), .pop(q_pop),
        .out_chan(out_chan)
    );

endmodule

>>> tb/tb_flic_chunk_decoder.sv
// Self-checking testbench for the FLIC sub-chunk decoder: random chunks, sizes, stalls.
`timescale 1ns / 100ps

module tb_flic_chunk_decoder;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [8:0] cfg_data;

    cfd_chan_if #(.payload_t(cfd_pkg::in_item_t))  in_ch ();
    cfd_chan_if #(.payload_t(cfd_pkg::out_item_t)) out_ch ();

    flic_chunk_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_chan  (in_ch),
        .out_chan (out_ch)
    );

    // Stimulus and expected commands
    cfd_pkg::in_item_t  byte_stream[$];
    cfd_pkg::out_item_t pending_cmds[$];

    int errors;
    int n_items;
    int n_runs;
    int n_pals;
    int n_clears;
    int send_idle_pct;
    int recv_idle_pct;
    logic hold_req;
    int   hold_left;

    // Decoder state mirror
    logic [8:0] canvas_w;
    logic [7:0] canvas_h;
    cfd_pkg::phase_t ph;
    cfd_pkg::chunk_t chunk;
    longint unsigned col, row, rbase, pkts, lines, cnt, cidx, held, cpos;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned eff_w();
        if (canvas_w < 1) return 1;
        if (canvas_w > 320) return 320;
        return canvas_w;
    endfunction

    function automatic longint unsigned eff_h();
        if (canvas_h < 1) return 1;
        if (canvas_h > 200) return 200;
        return canvas_h;
    endfunction

    function automatic longint unsigned sat16(longint unsigned v);
        return (v > 65535) ? 65535 : v;
    endfunction

    // Pixel run clipped to the canvas bound
    function automatic bit make_run(longint unsigned addr, longint unsigned len,
                                    logic [7:0] f, logic [7:0] s, bit two,
                                    output cfd_pkg::out_item_t o);
        longint unsigned npix;
        npix = eff_w() * eff_h();
        o = '0;
        if (addr >= npix || len == 0) return 0;
        if (len > npix - addr) len = npix - addr;
        o.command = cfd_pkg::CMD_RUN;
        o.start_address = addr[15:0];
        o.run_length = len[8:0];
        o.first_value = f;
        if (two)
        begin
            o.second_value = s;
            o.two_value_pattern = 1'b1;
        end
        return 1;
    endfunction

    function automatic void lc_line_done();
        row = sat16(row + 1);
        lines = (lines - 1) & 16'hFFFF;
        ph = (lines == 0) ? cfd_pkg::PH_IDLE : cfd_pkg::PH_LPKTS;
    endfunction

    function automatic void lc_pkt_done();
        pkts = (pkts - 1) & 16'hFFFF;
        if (pkts == 0) lc_line_done();
        else ph = cfd_pkg::PH_LSKIP;
    endfunction

    function automatic void ss_line_done();
        row = sat16(row + 1);
        lines = (lines - 1) & 16'hFFFF;
        ph = (lines == 0) ? cfd_pkg::PH_IDLE : cfd_pkg::PH_SOP_LO;
    endfunction

    function automatic void ss_pkt_done();
        pkts = (pkts - 1) & 16'hFFFF;
        if (pkts == 0) ss_line_done();
        else ph = cfd_pkg::PH_SSKIP;
    endfunction

    function automatic void br_row_done();
        row = row + 1;
        ph = (row >= eff_h()) ? cfd_pkg::PH_IDLE : cfd_pkg::PH_BHEAD;
    endfunction

    function automatic void br_after_write();
        if (col >= eff_w()) br_row_done();
        else ph = cfd_pkg::PH_BCODE;
    endfunction

    // Start marker: clear the chunk state and select the decoder
    function automatic bit open_chunk(logic [15:0] t, output cfd_pkg::out_item_t o);
        o = '0;
        col = 0; row = 0; rbase = 0; pkts = 0; lines = 0;
        cnt = 0; cidx = 0; held = 0; cpos = 0;
        ph = cfd_pkg::PH_IDLE;
        chunk = cfd_pkg::AC_NONE;
        case (t)
            cfd_pkg::CT_COLOR256:
            begin
                chunk = cfd_pkg::AC_COLOR256; ph = cfd_pkg::PH_CPK_LO;
            end
            cfd_pkg::CT_COLOR64:
            begin
                chunk = cfd_pkg::AC_COLOR64; ph = cfd_pkg::PH_CPK_LO;
            end
            cfd_pkg::CT_COPY:
            begin
                chunk = cfd_pkg::AC_COPY; ph = cfd_pkg::PH_COPY;
            end
            cfd_pkg::CT_BYTERUN:
            begin
                chunk = cfd_pkg::AC_BYTERUN; ph = cfd_pkg::PH_BHEAD;
            end
            cfd_pkg::CT_LC:
            begin
                chunk = cfd_pkg::AC_LC; ph = cfd_pkg::PH_LST_LO;
            end
            cfd_pkg::CT_SS2:
            begin
                chunk = cfd_pkg::AC_SS2; ph = cfd_pkg::PH_SCNT_LO;
            end
            cfd_pkg::CT_BLACK:
            begin
                chunk = cfd_pkg::AC_BLACK;
                o.command = cfd_pkg::CMD_CLEAR;
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    // Next state and command for one accepted item
    function automatic bit decode_item(input cfd_pkg::in_item_t it,
                                       output cfd_pkg::out_item_t o);
        longint unsigned b, w, op;
        logic [7:0] rr, gg, bb;
        bit r;
        r = 0;
        o = '0;
        if (!it.kind) return open_chunk(it.chunk_type, o);
        b = it.data_byte;
        w = eff_w();
        case (ph)
            cfd_pkg::PH_CPK_LO: begin held = b; ph = cfd_pkg::PH_CPK_HI; end
            cfd_pkg::PH_CPK_HI:
            begin
                pkts = held | (b << 8);
                cidx = 0;
                ph = pkts ? cfd_pkg::PH_CSKIP : cfd_pkg::PH_IDLE;
            end
            cfd_pkg::PH_CSKIP:
            begin
                cidx += b;
                if (cidx > 256) cidx = 256;
                ph = cfd_pkg::PH_CCNT;
            end
            cfd_pkg::PH_CCNT: begin cnt = b ? b : 256; ph = cfd_pkg::PH_CR; end
            cfd_pkg::PH_CR: begin held = b; ph = cfd_pkg::PH_CG; end
            cfd_pkg::PH_CG:
            begin
                held = (held & 8'hFF) | (b << 8);
                ph = cfd_pkg::PH_CB;
            end
            cfd_pkg::PH_CB:
            begin
                rr = held[7:0];
                gg = held[15:8];
                bb = b[7:0];
                if (chunk == cfd_pkg::AC_COLOR64)
                begin
                    rr = rr << 2; gg = gg << 2; bb = bb << 2;
                end
                if (cidx < 256)
                begin
                    o.command = cfd_pkg::CMD_PAL;
                    o.palette_index = cidx[7:0];
                    o.red = rr; o.green = gg; o.blue = bb;
                    r = 1;
                    cidx++;
                end
                cnt--;
                if (cnt == 0)
                begin
                    pkts = (pkts - 1) & 16'hFFFF;
                    ph = pkts ? cfd_pkg::PH_CSKIP : cfd_pkg::PH_IDLE;
                end
                else ph = cfd_pkg::PH_CR;
            end
            cfd_pkg::PH_COPY:
                if (cpos < w * eff_h())
                begin
                    r = make_run(cpos, 1, b[7:0], 8'd0, 0, o);
                    cpos++;
                end
            cfd_pkg::PH_BHEAD:
            begin
                col = 0; rbase = row * w; ph = cfd_pkg::PH_BCODE;
            end
            cfd_pkg::PH_BCODE:
                if (b == 0) br_row_done();
                else if (b < 8'h80) begin cnt = b; ph = cfd_pkg::PH_BVAL; end
                else begin cnt = 256 - b; ph = cfd_pkg::PH_BLIT; end
            cfd_pkg::PH_BVAL:
            begin
                if (col < w)
                begin
                    op = (cnt > w - col) ? w - col : cnt;
                    r = make_run(rbase + col, op, b[7:0], 8'd0, 0, o);
                    col += op;
                end
                br_after_write();
            end
            cfd_pkg::PH_BLIT:
            begin
                if (col < w)
                begin
                    r = make_run(rbase + col, 1, b[7:0], 8'd0, 0, o);
                    col++;
                end
                cnt--;
                if (cnt == 0) br_after_write();
            end
            cfd_pkg::PH_LST_LO: begin held = b; ph = cfd_pkg::PH_LST_HI; end
            cfd_pkg::PH_LST_HI:
            begin
                row = held | (b << 8); ph = cfd_pkg::PH_LLN_LO;
            end
            cfd_pkg::PH_LLN_LO: begin held = b; ph = cfd_pkg::PH_LLN_HI; end
            cfd_pkg::PH_LLN_HI:
            begin
                lines = held | (b << 8);
                ph = (lines == 0) ? cfd_pkg::PH_IDLE : cfd_pkg::PH_LPKTS;
            end
            cfd_pkg::PH_LPKTS:
            begin
                pkts = b;
                col = 0;
                rbase = row * w;
                if (pkts == 0) lc_line_done();
                else ph = cfd_pkg::PH_LSKIP;
            end
            cfd_pkg::PH_LSKIP: begin col += b; ph = cfd_pkg::PH_LCODE; end
            cfd_pkg::PH_LCODE:
                if (b < 8'h80)
                begin
                    cnt = b;
                    if (cnt == 0) lc_pkt_done();
                    else ph = cfd_pkg::PH_LLIT;
                end
                else
                begin
                    cnt = 256 - b;
                    ph = cfd_pkg::PH_LVAL;
                end
            cfd_pkg::PH_LLIT:
            begin
                r = make_run(rbase + col, 1, b[7:0], 8'd0, 0, o);
                col++;
                cnt--;
                if (cnt == 0) lc_pkt_done();
            end
            cfd_pkg::PH_LVAL:
            begin
                r = make_run(rbase + col, cnt, b[7:0], 8'd0, 0, o);
                col += cnt;
                lc_pkt_done();
            end
            cfd_pkg::PH_SCNT_LO: begin held = b; ph = cfd_pkg::PH_SCNT_HI; end
            cfd_pkg::PH_SCNT_HI:
            begin
                lines = held | (b << 8);
                row = 0;
                ph = lines ? cfd_pkg::PH_SOP_LO : cfd_pkg::PH_IDLE;
            end
            cfd_pkg::PH_SOP_LO: begin held = b; ph = cfd_pkg::PH_SOP_HI; end
            cfd_pkg::PH_SOP_HI:
            begin
                op = held | (b << 8);
                if ((op & 16'hC000) == 16'hC000)
                begin
                    row = sat16(row + (32'h10000 - op));
                    ph = cfd_pkg::PH_SOP_LO;
                end
                else if ((op & 16'hC000) == 16'h8000)
                begin
                    r = make_run(row * w + (w - 1), 1, op[7:0], 8'd0, 0, o);
                    ph = cfd_pkg::PH_SOP_LO;
                end
                else
                begin
                    pkts = op & 16'h3FFF;
                    col = 0;
                    rbase = row * w;
                    if (pkts == 0) ss_line_done();
                    else ph = cfd_pkg::PH_SSKIP;
                end
            end
            cfd_pkg::PH_SSKIP: begin col += b; ph = cfd_pkg::PH_SCODE; end
            cfd_pkg::PH_SCODE:
                if (b < 8'h80)
                begin
                    cnt = b;
                    if (cnt == 0) ss_pkt_done();
                    else ph = cfd_pkg::PH_SLIT_LO;
                end
                else
                begin
                    cnt = 256 - b;
                    ph = cfd_pkg::PH_SRUN_LO;
                end
            cfd_pkg::PH_SLIT_LO: begin held = b; ph = cfd_pkg::PH_SLIT_HI; end
            cfd_pkg::PH_SLIT_HI:
            begin
                r = make_run(rbase + col, 2, held[7:0], b[7:0], 1, o);
                col += 2;
                cnt--;
                if (cnt == 0) ss_pkt_done();
                else ph = cfd_pkg::PH_SLIT_LO;
            end
            cfd_pkg::PH_SRUN_LO: begin held = b; ph = cfd_pkg::PH_SRUN_HI; end
            cfd_pkg::PH_SRUN_HI:
            begin
                r = make_run(rbase + col, cnt * 2, held[7:0], b[7:0], 1, o);
                col += cnt * 2;
                ss_pkt_done();
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic chk(string name, int got, int want);
        if (got != want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_cmd(cfd_pkg::out_item_t got);
        cfd_pkg::out_item_t want;
        if (pending_cmds.size() == 0)
        begin
            report("command with none outstanding");
            return;
        end
        want = pending_cmds.pop_front();
        chk("command", got.command, want.command);
        chk("start_address", got.start_address, want.start_address);
        chk("run_length", got.run_length, want.run_length);
        chk("first_value", got.first_value, want.first_value);
        chk("second_value", got.second_value, want.second_value);
        chk("two_value_pattern", got.two_value_pattern, want.two_value_pattern);
        chk("palette_index", got.palette_index, want.palette_index);
        chk("red", got.red, want.red);
        chk("green", got.green, want.green);
        chk("blue", got.blue, want.blue);
        case (want.command)
            cfd_pkg::CMD_RUN: n_runs++;
            cfd_pkg::CMD_PAL: n_pals++;
            default: n_clears++;
        endcase
    endtask

    // Driver: predict on acceptance, then offer the next item
    always @(posedge clk)
    begin
        cfd_pkg::out_item_t o;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                n_items++;
                if (decode_item(in_ch.payload, o)) pending_cmds.push_back(o);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (byte_stream.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    in_ch.payload <= byte_stream.pop_front();
                    in_ch.valid <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req) hold_left <= 400;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready) check_cmd(out_ch.payload);
        out_ch.ready <= rst_n && hold_left == 0 && !hold_req
                        && $urandom_range(99, 0) >= recv_idle_pct;
    end

    // Item builders
    task automatic put_start(logic [15:0] t);
        cfd_pkg::in_item_t it;
        it.kind = 1'b0;
        it.chunk_type = t;
        it.data_byte = $urandom;
        byte_stream.push_back(it);
    endtask

    task automatic put_byte(int b);
        cfd_pkg::in_item_t it;
        it.kind = 1'b1;
        it.chunk_type = $urandom;
        it.data_byte = b[7:0];
        byte_stream.push_back(it);
    endtask

    task automatic put_word(int v);
        put_byte(v & 8'hFF);
        put_byte((v >> 8) & 8'hFF);
    endtask

    task automatic gen_color();
        int np, n;
        np = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(3, 1);
        put_word(np);
        repeat (np)
        begin
            put_byte(($urandom_range(9, 0) == 0) ? $urandom_range(255, 0)
                                                 : $urandom_range(40, 0));
            n = $urandom_range(4, 1);
            put_byte(n);
            repeat (3 * n) put_byte($urandom);
        end
    endtask

    task automatic gen_byterun();
        int rows, c, n, w;
        w = eff_w();
        rows = $urandom_range((eff_h() > 3) ? 3 : eff_h(), 1);
        repeat (rows)
        begin
            put_byte($urandom);
            c = 0;
            while (c < w)
            begin
                n = $urandom_range(99, 0);
                if (n < 8)
                begin
                    put_byte(0);
                    break;
                end
                else if (n < 55)
                begin
                    n = $urandom_range(127, 1);
                    put_byte(n);
                    put_byte($urandom);
                end
                else
                begin
                    n = $urandom_range(6, 1);
                    put_byte(256 - n);
                    repeat (n) put_byte($urandom);
                end
                c += n;
            end
        end
    endtask

    task automatic gen_lc();
        int nl, np, n;
        case ($urandom_range(9, 0))
            0: put_word($urandom_range(65535, 0));
            1: put_word(65534);
            default: put_word($urandom_range(eff_h() - 1, 0));
        endcase
        nl = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(3, 1);
        put_word(nl);
        repeat (nl)
        begin
            np = $urandom_range(3, 0);
            put_byte(np);
            repeat (np)
            begin
                put_byte($urandom_range((eff_w() > 255) ? 255 : eff_w(), 0));
                if ($urandom_range(1, 0))
                begin
                    n = $urandom_range(4, 0);
                    put_byte(n);
                    repeat (n) put_byte($urandom);
                end
                else
                begin
                    put_byte($urandom_range(255, 128));
                    put_byte($urandom);
                end
            end
        end
    endtask

    task automatic gen_ss2();
        int nl, np, n;
        nl = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(3, 1);
        put_word(nl);
        repeat (nl)
        begin
            if ($urandom_range(4, 0) == 0)
                put_word(32'h10000 - (($urandom_range(9, 0) == 0) ? $urandom_range(16384, 1)
                                                                  : $urandom_range(3, 1)));
            if ($urandom_range(4, 0) == 0)
                put_word(16'h8000 | $urandom_range(16'h3FFF, 0));
            np = $urandom_range(3, 0);
            put_word(np | (($urandom_range(3, 0) == 0) ? 16'h4000 : 0));
            repeat (np)
            begin
                put_byte($urandom_range((eff_w() > 255) ? 255 : eff_w(), 0));
                if ($urandom_range(1, 0))
                begin
                    n = $urandom_range(3, 0);
                    put_byte(n);
                    repeat (2 * n) put_byte($urandom);
                end
                else
                begin
                    put_byte($urandom_range(255, 128));
                    put_word($urandom);
                end
            end
        end
    endtask

    // Random chunk mix: mostly well formed, some cut short, some noise
    task automatic gen_random(int target);
        int top, k, cut;
        top = byte_stream.size() + target;
        while (byte_stream.size() < top)
        begin
            k = byte_stream.size();
            case ($urandom_range(10, 0))
                0: begin put_start(cfd_pkg::CT_COLOR256); gen_color(); end
                1: begin put_start(cfd_pkg::CT_COLOR64); gen_color(); end
                2:
                begin
                    put_start(cfd_pkg::CT_COPY);
                    repeat ($urandom_range(20, 1)) put_byte($urandom);
                end
                3, 4: begin put_start(cfd_pkg::CT_BYTERUN); gen_byterun(); end
                5, 6: begin put_start(cfd_pkg::CT_LC); gen_lc(); end
                7, 8: begin put_start(cfd_pkg::CT_SS2); gen_ss2(); end
                9: put_start(($urandom_range(1, 0)) ? cfd_pkg::CT_BLACK : 16'($urandom));
                default: repeat ($urandom_range(4, 1)) put_byte($urandom);
            endcase
            // broken chunk or surplus bytes
            if ($urandom_range(9, 0) == 0)
            begin
                cut = $urandom_range(byte_stream.size() - k - 1, 0);
                repeat (cut) void'(byte_stream.pop_back());
            end
            else if ($urandom_range(9, 0) == 0)
                repeat ($urandom_range(3, 1)) put_byte($urandom);
        end
    endtask

    task automatic cfg_write(logic idx, logic [8:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        if (idx == cfd_pkg::CFG_WIDTH) canvas_w = v;
        else canvas_h = v[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_canvas(int w, int h);
        cfg_write(cfd_pkg::CFG_WIDTH, w[8:0]);
        cfg_write(cfd_pkg::CFG_HEIGHT, h[8:0]);
    endtask

    // Wait until every item is taken and every command has come out
    task automatic drain();
        while (byte_stream.size() > 0 || in_ch.valid || pending_cmds.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        int pw[7] = '{320, 0, 511, 1, 7, 16, 320};
        int phh[7] = '{200, 0, 255, 1, 3, 9, 200};
        cfd_pkg::out_item_t unused_cmd;
        errors = 0; n_items = 0; n_runs = 0; n_pals = 0; n_clears = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = cfd_pkg::CFG_WIDTH;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle_pct = 6;
        recv_idle_pct = 81;
        canvas_w = 320;
        canvas_h = 200;
        void'(open_chunk(16'hFFFF, unused_cmd));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: small 4x2 canvas
        set_canvas(4, 2);
        put_byte(8'h55);
        put_start(cfd_pkg::CT_BLACK);
        put_start(cfd_pkg::CT_COLOR256);
        put_word(1); put_byte(255); put_byte(2);
        put_byte(8'hFF); put_byte(8'h00); put_byte(8'h80);
        put_byte(8'h01); put_byte(8'h02); put_byte(8'h03);
        put_start(cfd_pkg::CT_COLOR64);
        put_word(1); put_byte(0); put_byte(1);
        put_byte(8'h3F); put_byte(8'h40); put_byte(8'hFF);
        put_start(cfd_pkg::CT_BYTERUN);
        put_byte(0); put_byte(0);
        put_byte(0); put_byte(8'h7F); put_byte(8'hAA);
        put_byte(8'h99);
        put_start(cfd_pkg::CT_COPY);
        repeat (9) put_byte($urandom);
        put_start(cfd_pkg::CT_SS2);
        put_word(1); put_word(16'h4001); put_byte(1); put_byte(8'hFF); put_word(16'h3412);
        put_start(cfd_pkg::CT_LC);
        put_word(0);
        put_start(16'hFFFF);
        put_byte(8'h00);
        gen_random(60);
        drain();

        for (int i = 0; i < 7; i++)
        begin
            if (i == 3) begin send_idle_pct = 81; recv_idle_pct = 6; end
            if (i == 5) begin send_idle_pct = 0; recv_idle_pct = 0; end
            set_canvas(pw[i], phh[i]);
            gen_random(115);
            if (i == 5)
            begin
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            drain();
        end

        $display("Covered %0d items over 7 distinct canvas sizes, all seven chunk decoders.",
                 n_items);
        $display("Checked %0d pixel runs, %0d palette entries, %0d clears.",
                 n_runs, n_pals, n_clears);
        if (errors == 0)
            $display("tb_flic_chunk_decoder: clean");
        else
            $display("tb_flic_chunk_decoder: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_flic_chunk_decoder: errors");
        $finish;
    end

endmodule
